>>> rtl/gcc_pkg.sv
package gcc_pkg;

    // grid size
    localparam int GRID_COLS = 16;
    localparam int GRID_ROWS = 16;
    localparam int NTERM     = 3;
    localparam int NBANK     = 4;

    // node index widths
    localparam int CI_W  = $clog2(GRID_COLS);
    localparam int RI_W  = $clog2(GRID_ROWS);
    localparam int IDX_W = (CI_W > RI_W) ? CI_W : RI_W;

    // bank address widths (half index per axis plus table bit)
    localparam int HC_W      = (CI_W > 1) ? CI_W - 1 : 1;
    localparam int HR_W      = (RI_W > 1) ? RI_W - 1 : 1;
    localparam int MEM_AW    = 1 + HC_W + HR_W;
    localparam int MEM_DEPTH = 2 ** MEM_AW;

    // fixed point
    localparam int ONE_Q16  = 65536;
    localparam int HALF_Q16 = 32768;

    // divider and weight widths
    localparam int QW    = 16 + IDX_W;
    localparam int DEN_W = 34;
    localparam int WH_W  = 18;
    localparam int CW_W  = 19;

    // pipeline lengths
    localparam int AXIS_LAT  = QW + 3;
    localparam int BLEND_LAT = 5;

    // result buffer
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // item kinds
    localparam logic [1:0] KIND_FWD      = 2'd0;
    localparam logic [1:0] KIND_INV      = 2'd1;
    localparam logic [1:0] KIND_LOAD_ACT = 2'd2;
    localparam logic [1:0] KIND_LOAD_THY = 2'd3;

    // register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] CFG_STEP_X   = 3'd2;
    localparam logic [REG_IDX_W-1:0] CFG_STEP_Y   = 3'd3;
    localparam logic [REG_IDX_W-1:0] CFG_TBL_VLD  = 3'd4;

    // coefficient words, [axis][term][corner]
    typedef logic [1:0][NTERM-1:0][3:0][31:0] coef_arr_t;

    typedef struct packed {
        logic            en;
        logic            tbl;
        logic            axis;
        logic [CI_W-1:0] col;
        logic [RI_W-1:0] row;
        logic [1:0]      term;
        logic [31:0]     data;
    } coef_wr_t;

    typedef struct packed {
        logic            tbl;
        logic [CI_W-1:0] ix;
        logic [RI_W-1:0] iy;
    } coef_rd_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic is_load(input logic [1:0] kind);
        return (kind == KIND_LOAD_ACT) || (kind == KIND_LOAD_THY);
    endfunction

endpackage

>>> rtl/gcc_ifs.sv
interface gcc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic               coeff_axis;
    logic [3:0]         node_col;
    logic [3:0]         node_row;
    logic [1:0]         coeff_term;
    logic signed [31:0] coeff_value;

    modport source (output valid, kind, x_in, y_in, coeff_axis, node_col, node_row,
                    coeff_term, coeff_value, input ready);
    modport sink (input valid, kind, x_in, y_in, coeff_axis, node_col, node_row,
                  coeff_term, coeff_value, output ready);
endinterface

interface gcc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;

    modport source (output valid, x_out, y_out, input ready);
    modport sink (input valid, x_out, y_out, output ready);
endinterface

interface gcc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gcc_pkg::REG_IDX_W-1:0]  reg_index;
    logic [31:0]                    wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/gcc_axis.sv
module gcc_axis (
    input  logic                            clk,
    input  logic signed [31:0]              pos,
    input  logic signed [31:0]              org,
    input  logic [30:0]                     step,
    input  logic [gcc_pkg::IDX_W-1:0]       last,
    output logic [gcc_pkg::IDX_W-1:0]       idx,
    output logic signed [gcc_pkg::WH_W-1:0] whi
);

    localparam int QW    = gcc_pkg::QW;
    localparam int DEN_W = gcc_pkg::DEN_W;
    localparam int IDX_W = gcc_pkg::IDX_W;
    localparam int WH_W  = gcc_pkg::WH_W;
    localparam int LIM_W = 31 + IDX_W;

    localparam logic [1:0] SEL_INNER  = 2'd0;
    localparam logic [1:0] SEL_BELOW  = 2'd1;
    localparam logic [1:0] SEL_BEYOND = 2'd2;

    logic signed [32:0] off_reg, off_next;
    logic [30:0]        stp_reg, stp_next;
    logic [LIM_W-1:0]   lim_reg, lim_next;

    logic [DEN_W-1:0] rem_reg [QW+1];
    logic [QW-1:0]    qn_reg  [QW+1];
    logic [DEN_W-1:0] den_reg [QW+1];
    logic [1:0]       sel_reg [QW+1];

    logic [DEN_W-1:0] rem_next [QW];
    logic [QW-1:0]    qn_next  [QW];
    logic [DEN_W-1:0] rem0_next, den0_next;
    logic [QW-1:0]    qn0_next;
    logic [1:0]       sel0_next;

    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic signed [WH_W-1:0] whi_reg, whi_next;

    // offset from first node and position of last node
    always_comb
    begin
        off_next = {pos[31], pos} - {org[31], org};
        stp_next = (step == 31'd0) ? 31'd1 : step;
        lim_next = LIM_W'(stp_next) * LIM_W'(last);
    end

    // pick the case and set up the dividend and divisor
    always_comb
    begin : setup
        logic [32:0]      neg;
        logic [LIM_W-1:0] dif;
        logic [31:0]      n;
        logic [47:0]      num;
        neg = -off_reg;
        dif = LIM_W'(off_reg[31:0]) - lim_reg;
        if (off_reg[32])
        begin
            sel0_next = SEL_BELOW;
            n         = neg[31:0];
        end
        else if (LIM_W'(off_reg[31:0]) >= lim_reg)
        begin
            sel0_next = SEL_BEYOND;
            n         = dif[31:0];
        end
        else
        begin
            sel0_next = SEL_INNER;
            n         = off_reg[31:0];
        end
        if (sel0_next == SEL_INNER)
            den0_next = DEN_W'(stp_reg);
        else
            den0_next = DEN_W'({n, 1'b0}) + DEN_W'(stp_reg);
        num       = {n, 16'h0000};
        rem0_next = DEN_W'(num[47:QW]);
        qn0_next  = num[QW-1:0];
    end

    // one quotient bit per stage
    always_comb
    begin : divstep
        logic [DEN_W:0] sh;
        logic           ge;
        for (int s = 1; s <= QW; s++)
        begin
            sh = {rem_reg[s-1], qn_reg[s-1][QW-1]};
            ge = sh >= {1'b0, den_reg[s-1]};
            rem_next[s-1] = ge ? DEN_W'(sh - {1'b0, den_reg[s-1]}) : DEN_W'(sh);
            qn_next[s-1]  = {qn_reg[s-1][QW-2:0], ge};
        end
    end

    // node index and weight toward the upper node
    always_comb
    begin : finish
        logic [QW-1:0]    q;
        logic [QW:0]      tr;
        logic [IDX_W:0]   iv;
        logic [IDX_W-1:0] base;
        logic [QW+1:0]    diff;
        q    = qn_reg[QW];
        tr   = {1'b0, q} + (QW+1)'(gcc_pkg::HALF_Q16);
        iv   = tr[QW:16];
        base = last - IDX_W'(1);
        if (iv < {1'b0, last})
            base = iv[IDX_W-1:0];
        diff = (QW+2)'(q) - (QW+2)'({base, 16'h0000});
        unique case (sel_reg[QW])
            SEL_BELOW:
            begin
                idx_next = '0;
                whi_next = WH_W'(q);
            end
            SEL_BEYOND:
            begin
                idx_next = last - IDX_W'(1);
                whi_next = WH_W'(gcc_pkg::ONE_Q16) - WH_W'(q);
            end
            default:
            begin
                idx_next = base;
                whi_next = diff[WH_W-1:0];
            end
        endcase
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        stp_reg    <= stp_next;
        lim_reg    <= lim_next;
        rem_reg[0] <= rem0_next;
        qn_reg[0]  <= qn0_next;
        den_reg[0] <= den0_next;
        sel_reg[0] <= sel0_next;
        for (int s = 1; s <= QW; s++)
        begin
            rem_reg[s] <= rem_next[s-1];
            qn_reg[s]  <= qn_next[s-1];
            den_reg[s] <= den_reg[s-1];
            sel_reg[s] <= sel_reg[s-1];
        end
        idx_reg <= idx_next;
        whi_reg <= whi_next;
    end

    assign idx = idx_reg;
    assign whi = whi_reg;

endmodule

>>> rtl/gcc_coef_mem.sv
module gcc_coef_mem (
    input  logic                clk,
    input  gcc_pkg::coef_rd_t   rd,
    input  gcc_pkg::coef_wr_t   wr,
    output gcc_pkg::coef_arr_t  coef
);

    localparam int CI_W   = gcc_pkg::CI_W;
    localparam int RI_W   = gcc_pkg::RI_W;
    localparam int HC_W   = gcc_pkg::HC_W;
    localparam int HR_W   = gcc_pkg::HR_W;
    localparam int MEM_AW = gcc_pkg::MEM_AW;
    localparam int NBANK  = gcc_pkg::NBANK;
    localparam int NTERM  = gcc_pkg::NTERM;

    logic [MEM_AW-1:0] rd_addr [NBANK];
    logic [MEM_AW-1:0] wr_addr;
    logic [31:0]       bank_q  [NBANK][2][NTERM];
    logic [1:0]        par_reg;

    // each bank holds one column parity and one row parity
    always_comb
    begin : addr
        logic [CI_W-1:0] cb;
        logic [RI_W-1:0] rb;
        for (int b = 0; b < NBANK; b++)
        begin
            cb = rd.ix + CI_W'(rd.ix[0] ^ b[0]);
            rb = rd.iy + RI_W'(rd.iy[0] ^ b[1]);
            rd_addr[b] = {rd.tbl, HC_W'(cb >> 1), HR_W'(rb >> 1)};
        end
        wr_addr = {wr.tbl, HC_W'(wr.col >> 1), HR_W'(wr.row >> 1)};
    end

    for (genvar b = 0; b < NBANK; b++)
    begin : g_bank
        localparam logic BC = 1'(b % 2);
        localparam logic BR = 1'(b / 2);
        for (genvar a = 0; a < 2; a++)
        begin : g_axis
            for (genvar t = 0; t < NTERM; t++)
            begin : g_term
                logic [31:0] mem [gcc_pkg::MEM_DEPTH];
                logic [31:0] q_reg;

                // one coefficient lane of one bank
                always_ff @(posedge clk)
                begin
                    if (wr.en && wr.col[0] == BC && wr.row[0] == BR &&
                        wr.axis == 1'(a) && wr.term == 2'(t))
                        mem[wr_addr] <= wr.data;
                    q_reg <= mem[rd_addr[b]];
                end

                assign bank_q[b][a][t] = q_reg;
            end
        end
    end

    // remember parities to route banks to corners
    always_ff @(posedge clk)
    begin
        par_reg <= {rd.iy[0], rd.ix[0]};
    end

    always_comb
    begin : route
        logic [1:0] bsel;
        for (int k = 0; k < 4; k++)
        begin
            bsel = 2'(k) ^ par_reg;
            for (int a = 0; a < 2; a++)
                for (int t = 0; t < NTERM; t++)
                    coef[a][t][k] = bank_q[bsel][a][t];
        end
    end

endmodule

>>> rtl/gcc_blend.sv
module gcc_blend (
    input  logic                            clk,
    input  logic signed [gcc_pkg::WH_W-1:0] whx,
    input  logic signed [gcc_pkg::WH_W-1:0] why,
    input  logic signed [31:0]              x,
    input  logic signed [31:0]              y,
    input  gcc_pkg::coef_arr_t              coef,
    input  logic                            bypass,
    output logic signed [31:0]              x_res,
    output logic signed [31:0]              y_res
);

    localparam int WH_W  = gcc_pkg::WH_W;
    localparam int CW_W  = gcc_pkg::CW_W;
    localparam int P_W   = CW_W + 32;
    localparam int ACC_W = P_W + 2;
    localparam int NTERM = gcc_pkg::NTERM;

    logic signed [CW_W-1:0] cw_reg   [4];
    logic signed [CW_W-1:0] cw_next  [4];
    logic signed [P_W-1:0]  prod_reg [2][NTERM][4];
    logic signed [P_W-1:0]  prod_next[2][NTERM][4];
    logic signed [31:0]     c_reg    [2][NTERM];
    logic signed [31:0]     c_next   [2][NTERM];
    logic signed [47:0]     tx_reg   [2][2];
    logic signed [47:0]     tx_next  [2][2];
    logic signed [31:0]     c0_reg   [2];
    logic signed [31:0]     xp_reg   [4];
    logic signed [31:0]     yp_reg   [4];
    logic signed [31:0]     xr_reg, xr_next;
    logic signed [31:0]     yr_reg, yr_next;

    // corner weights
    always_comb
    begin : weights
        logic signed [WH_W-1:0]   wxl, wyl, wa, wb;
        logic signed [2*WH_W-1:0] pr, sh;
        wxl = WH_W'(gcc_pkg::ONE_Q16) - whx;
        wyl = WH_W'(gcc_pkg::ONE_Q16) - why;
        for (int k = 0; k < 4; k++)
        begin
            wa = k[0] ? whx : wxl;
            wb = k[1] ? why : wyl;
            pr = wb * wa;
            sh = (pr + (2*WH_W)'(gcc_pkg::HALF_Q16)) >>> 16;
            cw_next[k] = sh[CW_W-1:0];
        end
    end

    // weight times coefficient
    always_comb
    begin
        for (int a = 0; a < 2; a++)
            for (int t = 0; t < NTERM; t++)
                for (int k = 0; k < 4; k++)
                    prod_next[a][t][k] = cw_reg[k] * $signed(coef[a][t][k]);
    end

    // blended coefficients
    always_comb
    begin : blend
        logic signed [ACC_W-1:0] acc, rn;
        for (int a = 0; a < 2; a++)
            for (int t = 0; t < NTERM; t++)
            begin
                acc = ACC_W'(prod_reg[a][t][0]) + ACC_W'(prod_reg[a][t][1])
                    + ACC_W'(prod_reg[a][t][2]) + ACC_W'(prod_reg[a][t][3]);
                rn = (acc + ACC_W'(gcc_pkg::HALF_Q16)) >>> 16;
                c_next[a][t] = gcc_pkg::sat32(64'(rn));
            end
    end

    // c1*x and c2*y
    always_comb
    begin : terms
        logic signed [63:0] m, r;
        for (int a = 0; a < 2; a++)
        begin
            m = c_reg[a][1] * xp_reg[2];
            r = (m + 64'(gcc_pkg::HALF_Q16)) >>> 16;
            tx_next[a][0] = r[47:0];
            m = c_reg[a][2] * yp_reg[2];
            r = (m + 64'(gcc_pkg::HALF_Q16)) >>> 16;
            tx_next[a][1] = r[47:0];
        end
    end

    // final sum or pass through
    always_comb
    begin : sum
        logic signed [63:0] sx, sy;
        sx = 64'(c0_reg[0]) + 64'(tx_reg[0][0]) + 64'(tx_reg[0][1]);
        sy = 64'(c0_reg[1]) + 64'(tx_reg[1][0]) + 64'(tx_reg[1][1]);
        xr_next = bypass ? xp_reg[3] : gcc_pkg::sat32(sx);
        yr_next = bypass ? yp_reg[3] : gcc_pkg::sat32(sy);
    end

    always_ff @(posedge clk)
    begin
        cw_reg   <= cw_next;
        prod_reg <= prod_next;
        c_reg    <= c_next;
        tx_reg   <= tx_next;
        c0_reg[0] <= c_reg[0][0];
        c0_reg[1] <= c_reg[1][0];
        xp_reg[0] <= x;
        yp_reg[0] <= y;
        for (int s = 1; s < 4; s++)
        begin
            xp_reg[s] <= xp_reg[s-1];
            yp_reg[s] <= yp_reg[s-1];
        end
        xr_reg <= xr_next;
        yr_reg <= yr_next;
    end

    assign x_res = xr_reg;
    assign y_res = yr_reg;

endmodule

>>> rtl/grid_coefficient_correction.sv
// grid coefficient correction: maps a point (x_in, y_in) in signed Q16.16 to a
// corrected point through a bilinear blend of per-node affine coefficients.
// pt_in takes one beat per cycle while pt_in.ready is high: kind 0/1 are forward/inverse corrections,
// kind 2/3 load one coefficient word into the actual/theory table.
// pt_out gives one beat (x_out, y_out) per correction, in order; loads give none.
// cfg writes origin, step and tables_valid; write only while the block is idle.
// path: a correction beat passes the input register, both axis dividers, the
// coefficient read and the blend pipeline, then enters the result buffer.
// throughput: one item per clock while pt_in.ready is high; the per-axis divider
// is a pipeline with one quotient bit per stage and the four coefficient banks
// deliver all 24 words in one read, so neither limits the rate.
// stall: results queue in a 32-beat buffer; pt_in.ready drops while 32
// corrections are in flight or waiting, and the pipeline itself never stalls.
// reset: config registers return to their reset values and the buffer empties;
// coefficient tables are not cleared and must be loaded before use.
module grid_coefficient_correction (
    input  logic       clk,
    input  logic       rst_n,
    gcc_in_if.sink     pt_in,
    gcc_out_if.source  pt_out,
    gcc_cfg_if.sink    cfg
);

    localparam int AXIS_LAT  = gcc_pkg::AXIS_LAT;
    localparam int BLEND_LAT = gcc_pkg::BLEND_LAT;
    localparam int FIFO_AW   = gcc_pkg::FIFO_AW;
    localparam int IDX_W     = gcc_pkg::IDX_W;
    localparam int WH_W      = gcc_pkg::WH_W;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               axis;
        logic [3:0]         col;
        logic [3:0]         row;
        logic [1:0]         term;
        logic [31:0]        value;
    } item_t;

    // config registers
    logic signed [31:0] org_x_reg, org_y_reg;
    logic [30:0]        step_x_reg, step_y_reg;
    logic               tbl_vld_reg;

    // pipeline
    logic                    accept;
    item_t                   s0_reg;
    logic                    s0v_reg;
    item_t                   dl_reg  [AXIS_LAT];
    logic [AXIS_LAT-1:0]     dlv_reg;
    logic [BLEND_LAT-1:0]    rv_reg;
    item_t                   mi;
    logic                    mv;
    logic [IDX_W-1:0]        ix, iy;
    logic signed [WH_W-1:0]  whx, why;
    gcc_pkg::coef_rd_t       rd;
    gcc_pkg::coef_wr_t       wr;
    gcc_pkg::coef_arr_t      coef;
    logic signed [31:0]      x_res, y_res;

    // result buffer
    logic [63:0]        fifo_mem [gcc_pkg::FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, rp_reg;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic [FIFO_AW:0]   crd_reg, crd_next;
    logic               push, pop, take;

    // config writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg   <= '0;
            org_y_reg   <= '0;
            step_x_reg  <= 31'(gcc_pkg::ONE_Q16);
            step_y_reg  <= 31'(gcc_pkg::ONE_Q16);
            tbl_vld_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                gcc_pkg::CFG_ORIGIN_X: org_x_reg   <= cfg.wdata;
                gcc_pkg::CFG_ORIGIN_Y: org_y_reg   <= cfg.wdata;
                gcc_pkg::CFG_STEP_X:   step_x_reg  <= cfg.wdata[30:0];
                gcc_pkg::CFG_STEP_Y:   step_y_reg  <= cfg.wdata[30:0];
                gcc_pkg::CFG_TBL_VLD:  tbl_vld_reg <= cfg.wdata[0];
                default: ;
            endcase
        end
    end

    // input beat capture
    assign pt_in.ready = crd_reg < (FIFO_AW+1)'(gcc_pkg::FIFO_DEPTH);
    assign accept      = pt_in.valid && pt_in.ready;
    assign take        = accept && !gcc_pkg::is_load(pt_in.kind);

    always_ff @(posedge clk)
    begin
        s0_reg.kind  <= pt_in.kind;
        s0_reg.x     <= pt_in.x_in;
        s0_reg.y     <= pt_in.y_in;
        s0_reg.axis  <= pt_in.coeff_axis;
        s0_reg.col   <= pt_in.node_col;
        s0_reg.row   <= pt_in.node_row;
        s0_reg.term  <= pt_in.coeff_term;
        s0_reg.value <= pt_in.coeff_value;
        dl_reg[0]    <= s0_reg;
        for (int s = 1; s < AXIS_LAT; s++)
            dl_reg[s] <= dl_reg[s-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0v_reg <= 1'b0;
            dlv_reg <= '0;
            rv_reg  <= '0;
        end
        else
        begin
            s0v_reg <= accept;
            dlv_reg <= {dlv_reg[AXIS_LAT-2:0], s0v_reg};
            rv_reg  <= {rv_reg[BLEND_LAT-2:0], mv && !gcc_pkg::is_load(mi.kind)};
        end
    end

    // cell and weights per axis
    gcc_axis u_axis_x (
        .clk  (clk),
        .pos  (s0_reg.x),
        .org  (org_x_reg),
        .step (step_x_reg),
        .last (IDX_W'(gcc_pkg::GRID_COLS - 1)),
        .idx  (ix),
        .whi  (whx)
    );

    gcc_axis u_axis_y (
        .clk  (clk),
        .pos  (s0_reg.y),
        .org  (org_y_reg),
        .step (step_y_reg),
        .last (IDX_W'(gcc_pkg::GRID_ROWS - 1)),
        .idx  (iy),
        .whi  (why)
    );

    // coefficient access: loads write in the same stage that corrections read
    assign mi = dl_reg[AXIS_LAT-1];
    assign mv = dlv_reg[AXIS_LAT-1];

    always_comb
    begin
        rd.tbl  = (mi.kind == gcc_pkg::KIND_INV);
        rd.ix   = gcc_pkg::CI_W'(ix);
        rd.iy   = gcc_pkg::RI_W'(iy);
        wr.en   = mv && gcc_pkg::is_load(mi.kind) && int'(mi.term) < gcc_pkg::NTERM
                  && int'(mi.col) < gcc_pkg::GRID_COLS && int'(mi.row) < gcc_pkg::GRID_ROWS;
        wr.tbl  = (mi.kind == gcc_pkg::KIND_LOAD_THY);
        wr.axis = mi.axis;
        wr.col  = gcc_pkg::CI_W'(mi.col);
        wr.row  = gcc_pkg::RI_W'(mi.row);
        wr.term = mi.term;
        wr.data = mi.value;
    end

    gcc_coef_mem u_mem (
        .clk  (clk),
        .rd   (rd),
        .wr   (wr),
        .coef (coef)
    );

    gcc_blend u_blend (
        .clk    (clk),
        .whx    (whx),
        .why    (why),
        .x      (mi.x),
        .y      (mi.y),
        .coef   (coef),
        .bypass (!tbl_vld_reg),
        .x_res  (x_res),
        .y_res  (y_res)
    );

    // result buffer and credits
    assign push = rv_reg[BLEND_LAT-1];
    assign pop  = pt_out.valid && pt_out.ready;

    always_comb
    begin
        cnt_next = cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        crd_next = crd_reg + (FIFO_AW+1)'(take) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wp_reg] <= {x_res, y_res};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            crd_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + FIFO_AW'(1);
            if (pop)
                rp_reg <= rp_reg + FIFO_AW'(1);
            cnt_reg <= cnt_next;
            crd_reg <= crd_next;
        end
    end

    assign pt_out.valid = cnt_reg != '0;
    assign pt_out.x_out = fifo_mem[rp_reg][63:32];
    assign pt_out.y_out = fifo_mem[rp_reg][31:0];

    // credits bound the buffer fill
    assert property (@(posedge clk) disable iff (!rst_n)
        crd_reg <= (FIFO_AW+1)'(gcc_pkg::FIFO_DEPTH))
        else $error("credit count above buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= crd_reg)
        else $error("buffer holds more beats than corrections in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> cnt_reg < (FIFO_AW+1)'(gcc_pkg::FIFO_DEPTH))
        else $error("result buffer overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid && !pt_out.ready |=>
            pt_out.valid && $stable(pt_out.x_out) && $stable(pt_out.y_out))
        else $error("output beat changed while stalled");

endmodule
